// ===== rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, types and helpers for the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int CoordWidth = 32;
	localparam int FracBits   = 16;
	localparam int DirWidth   = 18;
	// magnitude of a coordinate difference
	localparam int NumWidth   = CoordWidth + 1;
	// magnitude of the most negative direction needs every direction bit
	localparam int DenWidth   = DirWidth;
	// quotient bits kept before saturation: numerator bits plus fraction bits
	localparam int QuoWidth   = NumWidth + FracBits;
	// remainder must hold twice the denominator
	localparam int RemWidth   = DenWidth + 1;
	localparam int Cells      = QuoWidth;
	localparam int IdxWidth   = $clog2(Cells + 1);

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [DirWidth-1:0]   dir_t;

	// one division in flight through the cell row
	typedef struct packed {
		logic [RemWidth-1:0] rem;
		logic [QuoWidth-1:0] quo;
		logic [NumWidth-1:0] num;
		logic [DenWidth-1:0] den;
		logic                neg;
	} div_t;

	// per-axis side information carried beside the divisions
	typedef struct packed {
		logic zero;     // direction component is zero
		logic in_slab;  // origin within slab for a zero component
	} axis_t;

	// saturate an unsigned magnitude with sign to the coordinate range
	function automatic coord_t sat_quo(input logic [QuoWidth-1:0] q, input logic neg);
		logic [QuoWidth-1:0] lim;
		lim = {{(QuoWidth-CoordWidth){1'b0}}, 1'b1, {(CoordWidth-1){1'b0}}};
		if (!neg) begin
			if (q >= lim) sat_quo = {1'b0, {(CoordWidth-1){1'b1}}};
			else sat_quo = coord_t'(q[CoordWidth-1:0]);
		end else begin
			if (q >= lim) sat_quo = {1'b1, {(CoordWidth-1){1'b0}}};
			else sat_quo = coord_t'(-q[CoordWidth-1:0]);
		end
	endfunction

endpackage

// ===== rtl/rbsi_div_cell.sv =====
// ----------------------------------------------------------------------------
// rbsi_div_cell
// One restoring-division step: shifts in one numerator bit, retires one
// quotient bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module rbsi_div_cell (
	input  logic                 clk,
	input  logic [rbsi_pkg::IdxWidth-1:0] step,
	input  rbsi_pkg::div_t       d_in,
	output rbsi_pkg::div_t       d_s1
);

	logic                          bit_in;
	logic [rbsi_pkg::RemWidth-1:0] r_sh;
	rbsi_pkg::div_t                nxt;

	// bit index counts down over numerator then fraction zeros
	always_comb begin
		nxt = d_in;
		if (step >= rbsi_pkg::IdxWidth'(rbsi_pkg::FracBits))
			bit_in = d_in.num[step - rbsi_pkg::IdxWidth'(rbsi_pkg::FracBits)];
		else
			bit_in = 1'b0;
		r_sh = {d_in.rem[rbsi_pkg::RemWidth-2:0], bit_in};
		nxt.quo = {d_in.quo[rbsi_pkg::QuoWidth-2:0], 1'b0};
		if (r_sh >= {1'b0, d_in.den}) begin
			nxt.rem = r_sh - {1'b0, d_in.den};
			nxt.quo[0] = 1'b1;
		end else begin
			nxt.rem = r_sh;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= nxt;
	end

endmodule

// ===== rtl/rbsi_div_row.sv =====
// ----------------------------------------------------------------------------
// rbsi_div_row
// Row of division cells; one quotient bit per cell, one new division per cycle.
// ----------------------------------------------------------------------------
module rbsi_div_row (
	input  logic           clk,
	input  rbsi_pkg::div_t d_in,
	output rbsi_pkg::div_t d_out
);

	rbsi_pkg::div_t link [rbsi_pkg::Cells+1];

	assign link[0] = d_in;

	// cell k handles step Cells-1-k: numerator bit step-FracBits, or a fraction zero
	for (genvar k = 0; k < rbsi_pkg::Cells; k++) begin : g_cell
		rbsi_div_cell u_cell (
			.clk  (clk),
			.step (rbsi_pkg::IdxWidth'(rbsi_pkg::Cells - 1 - k)),
			.d_in (link[k]),
			.d_s1 (link[k+1])
		);
	end

	assign d_out = link[rbsi_pkg::Cells];

endmodule

// ===== rtl/ray_box_slab_intersection_top.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_top
// Ray against axis-aligned box by the slab method, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: drive a ray and a box on the input ports and raise start; busy is
// always low, so a transfer happens on every cycle that start is high.
// Each of the six slab times is a restoring division running through a row
// of 49 cells, one quotient bit per cell, so one item enters every cycle.
// From the start transfer to the done strobe the data pass one input stage,
// 49 division cells, one saturate stage and one merge/output stage.
// Throughput is one item per cycle.
// Results appear on hit and hit_distance for exactly one cycle, marked by
// done; the receiver cannot stall, and nothing is held back.
// Reset clears the valid line so no strobe follows reset; data registers
// carry no reset.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rbsi_pkg::coord_t origin_x,
	input  rbsi_pkg::coord_t origin_y,
	input  rbsi_pkg::coord_t origin_z,
	input  rbsi_pkg::dir_t   dir_x,
	input  rbsi_pkg::dir_t   dir_y,
	input  rbsi_pkg::dir_t   dir_z,
	input  rbsi_pkg::coord_t box_min_x,
	input  rbsi_pkg::coord_t box_min_y,
	input  rbsi_pkg::coord_t box_min_z,
	input  rbsi_pkg::coord_t box_max_x,
	input  rbsi_pkg::coord_t box_max_y,
	input  rbsi_pkg::coord_t box_max_z,
	output logic             done,
	output logic             hit,
	output rbsi_pkg::coord_t hit_distance
);

	localparam int Lat = rbsi_pkg::Cells;

	rbsi_pkg::coord_t o [3], mn [3], mx [3];
	rbsi_pkg::dir_t   d [3];
	rbsi_pkg::div_t   div_in_s1 [6];
	rbsi_pkg::div_t   div_out [6];
	rbsi_pkg::axis_t  ax_s1 [3];
	rbsi_pkg::axis_t  ax_line [Lat+1][3];
	rbsi_pkg::coord_t t_s2 [6];
	rbsi_pkg::axis_t  ax_s2 [3];
	logic [Lat+2:0]   vld_q;

	assign busy = 1'b0;
	assign o  = '{origin_x, origin_y, origin_z};
	assign d  = '{dir_x, dir_y, dir_z};
	assign mn = '{box_min_x, box_min_y, box_min_z};
	assign mx = '{box_max_x, box_max_y, box_max_z};

	// valid line, one bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat+1:0], start};
	end

	// input stage: magnitudes and signs of numerators and denominators
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [rbsi_pkg::NumWidth-1:0] nlo, nhi;
		logic                                 dneg;
		logic [rbsi_pkg::DenWidth-1:0]        dmag;
		logic signed [rbsi_pkg::DirWidth:0]   dext;
		always_comb begin
			dneg = d[a][rbsi_pkg::DirWidth-1];
			dext = {d[a][rbsi_pkg::DirWidth-1], d[a]};
			if (dneg) dext = -dext;
			dmag = dext[rbsi_pkg::DenWidth-1:0];
			// entry corner is lower for non-negative directions
			if (dneg) begin
				nlo = {mx[a][rbsi_pkg::CoordWidth-1], mx[a]} - {o[a][rbsi_pkg::CoordWidth-1], o[a]};
				nhi = {mn[a][rbsi_pkg::CoordWidth-1], mn[a]} - {o[a][rbsi_pkg::CoordWidth-1], o[a]};
			end else begin
				nlo = {mn[a][rbsi_pkg::CoordWidth-1], mn[a]} - {o[a][rbsi_pkg::CoordWidth-1], o[a]};
				nhi = {mx[a][rbsi_pkg::CoordWidth-1], mx[a]} - {o[a][rbsi_pkg::CoordWidth-1], o[a]};
			end
		end
		always_ff @(posedge clk) begin
			div_in_s1[2*a].rem   <= '0;
			div_in_s1[2*a].quo   <= '0;
			div_in_s1[2*a].num   <= nlo[rbsi_pkg::NumWidth-1] ? -nlo : nlo;
			div_in_s1[2*a].den   <= dmag;
			div_in_s1[2*a].neg   <= nlo[rbsi_pkg::NumWidth-1] ^ dneg;
			div_in_s1[2*a+1].rem <= '0;
			div_in_s1[2*a+1].quo <= '0;
			div_in_s1[2*a+1].num <= nhi[rbsi_pkg::NumWidth-1] ? -nhi : nhi;
			div_in_s1[2*a+1].den <= dmag;
			div_in_s1[2*a+1].neg <= nhi[rbsi_pkg::NumWidth-1] ^ dneg;
			ax_s1[a].zero        <= (d[a] == '0);
			ax_s1[a].in_slab     <= (mn[a] <= o[a]) && (o[a] <= mx[a]);
		end
	end

	// six division rows, one per slab time
	for (genvar k = 0; k < 6; k++) begin : g_div
		rbsi_div_row u_row (.clk(clk), .d_in(div_in_s1[k]), .d_out(div_out[k]));
	end

	// axis flags ride alongside the division rows
	assign ax_line[0] = ax_s1;
	for (genvar j = 0; j < Lat; j++) begin : g_line
		always_ff @(posedge clk) ax_line[j+1] <= ax_line[j];
	end

	// saturate quotients
	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) t_s2[k] <= rbsi_pkg::sat_quo(div_out[k].quo, div_out[k].neg);
		ax_s2 <= ax_line[Lat];
	end

	// merge the three intervals
	logic             h;
	logic             have;
	rbsi_pkg::coord_t lo, hi, res;
	always_comb begin
		h = 1'b1;
		have = 1'b0;
		lo = '0;
		hi = '0;
		for (int a = 0; a < 3; a++) begin
			if (h) begin
				if (ax_s2[a].zero) begin
					if (!ax_s2[a].in_slab) h = 1'b0;
				end else if (have && ((lo > t_s2[2*a+1]) || (t_s2[2*a] > hi))) begin
					h = 1'b0;
				end else begin
					if (!have || t_s2[2*a] > lo) lo = t_s2[2*a];
					if (!have || t_s2[2*a+1] < hi) hi = t_s2[2*a+1];
					have = 1'b1;
				end
			end
		end
		if (!h) res = '0;
		else if (have && lo > 0) res = lo;
		else if (have) res = hi;
		else res = {1'b0, {(rbsi_pkg::CoordWidth-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		hit          <= h;
		hit_distance <= res;
	end

	assign done = vld_q[Lat+2];

endmodule

// ===== rtl/rbsi_checker.sv =====
// ----------------------------------------------------------------------------
// rbsi_checker
// Port-level checks on the ray/box slab intersection block.
// ----------------------------------------------------------------------------
module rbsi_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             hit,
	input rbsi_pkg::coord_t hit_distance
);

	// never refuses a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// a done strobe follows each start
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(rbsi_pkg::Cells + 3) done) else $error("missing result");

	// no strobe without an earlier start
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, rbsi_pkg::Cells + 3)) else $error("spurious result");

	// a miss reports zero distance
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (hit_distance == '0)) else $error("miss with distance");

endmodule

bind ray_box_slab_intersection_top rbsi_checker u_rbsi_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .hit(hit), .hit_distance(hit_distance)
);
